FILE: design/skip_interval_log_histogram_core_macros.svh
// ----------------------------------------------------------------------------
// Skip-interval log histogram: assertion macros
// Implication checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SKIP_INTERVAL_LOG_HISTOGRAM_CORE_MACROS_SVH
`define SKIP_INTERVAL_LOG_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication.
`define SLH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/slh_pkg.sv
// ----------------------------------------------------------------------------
// Skip-interval log histogram package
// Shared codes, state encoding and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slh_pkg;

  localparam int SKIP_W      = 7;
  localparam int NBIN_W      = 7;
  localparam int CNT_W       = 32;
  localparam int CFG_AW      = 3;
  localparam int NBIN_RST    = 40;
  localparam int MIN_CUT_RST = 800;

  typedef enum logic [1:0] {
    ACT_HIT,
    ACT_READ,
    ACT_START,
    ACT_EDGE
  } action_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_SKIP,
    REG_BURST,
    REG_MIN_CUT,
    REG_MAX_TIME,
    REG_NBINS
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIMIT,
    S_BURST,
    S_KEEP,
    S_DIFF,
    S_SWEEP,
    S_RMW,
    S_WB,
    S_RDCNT,
    S_CNTCAP,
    S_RESP
  } state_e;

endpackage

FILE: design/slh_sub_cmp.sv
// ----------------------------------------------------------------------------
// Shared subtract and compare unit
// Works out a - b, flags a negative difference and a difference above lim.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slh_sub_cmp #(
  parameter int W = 48
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] lim_i,
  output logic [W-1:0] diff_o,
  output logic         neg_o,
  output logic         gt_o
);

  logic [W:0] diff_full;

  assign diff_full = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o    = diff_full[W-1:0];
  assign neg_o     = diff_full[W];
  // A negative difference never counts as later.
  assign gt_o      = !diff_full[W] && (diff_full[W-1:0] > lim_i);

endmodule

FILE: design/slh_window.sv
// ----------------------------------------------------------------------------
// Hit time window store
// Circular store of kept hit times, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slh_window #(
  parameter int DEPTH = 128,
  parameter int W     = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/slh_hist.sv
// ----------------------------------------------------------------------------
// Histogram storage
// Bin edge memory and bin count memory; counts carry valid bits so that a
// new run clears them at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slh_hist #(
  parameter int MAX_BINS = 64,
  parameter int W        = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             edge_we_i,
  input  logic [$clog2(MAX_BINS+1)-1:0]    edge_waddr_i,
  input  logic [W-1:0]                     edge_wdata_i,
  input  logic [$clog2(MAX_BINS+1)-1:0]    edge_raddr_i,
  output logic [W-1:0]                     edge_rdata_o,
  input  logic                             cnt_clr_i,
  input  logic                             cnt_we_i,
  input  logic [$clog2(MAX_BINS+2)-1:0]    cnt_waddr_i,
  input  logic [slh_pkg::CNT_W-1:0]        cnt_wdata_i,
  input  logic [$clog2(MAX_BINS+2)-1:0]    cnt_raddr_i,
  output logic [slh_pkg::CNT_W-1:0]        cnt_rdata_o
);

  localparam int NCNT = MAX_BINS + 2;

  logic [W-1:0]              edge_mem [MAX_BINS+1];
  logic [slh_pkg::CNT_W-1:0] cnt_mem  [NCNT];
  logic [NCNT-1:0]           cnt_vld_q;
  logic [slh_pkg::CNT_W-1:0] cnt_rd_q;
  logic                      cnt_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (edge_we_i) begin
      edge_mem[edge_waddr_i] <= edge_wdata_i;
    end
    edge_rdata_o <= edge_mem[edge_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    cnt_rd_q     <= cnt_mem[cnt_raddr_i];
    cnt_rd_vld_q <= cnt_vld_q[cnt_raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cnt_clr_i) begin
      cnt_vld_q <= '0;
    end else if (cnt_we_i) begin
      cnt_vld_q[cnt_waddr_i] <= 1'b1;
    end
  end

  // An entry not written since the run started reads as zero.
  assign cnt_rdata_o = cnt_rd_vld_q ? cnt_rd_q : '0;

endmodule

FILE: design/skip_interval_log_histogram_core.sv
// Sequence: a start run or edge write goes straight to the response, where done_o is high.
// A hit past the time limit ends there; with the burst check on, the burst cut may drop it;
// else it is kept, and ends if it fills nothing. A negative interval goes to bin 0, any other
// sweeps the edge memory for its bin; the count is then read, raised and written back. A read
// goes through count read and capture. Throughput: one request at a time; busy_o drops in the
// cycle after done_o. Reset: registers take reset values, counts read zero; no stalls.
// ----------------------------------------------------------------------------
// Skip-interval log histogram core
// Histograms intervals between kept hits into loaded bins under a sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "skip_interval_log_histogram_core_macros.svh"

module skip_interval_log_histogram_core #(
  parameter int WINDOW_DEPTH = 128,
  parameter int MAX_BINS     = 64,
  parameter int TIME_BITS    = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       action_i,
  input  logic [TIME_BITS-1:0]             timestamp_i,
  input  logic [$clog2(MAX_BINS+2)-1:0]    bin_index_i,
  input  logic [TIME_BITS-1:0]             edge_value_i,
  input  logic                             cfg_we_i,
  input  logic [slh_pkg::CFG_AW-1:0]       cfg_addr_i,
  input  logic [TIME_BITS-1:0]             cfg_wdata_i,
  output logic                             done_o,
  output logic                             hit_kept_o,
  output logic                             bin_filled_o,
  output logic [$clog2(MAX_BINS+2)-1:0]    filled_bin_o,
  output logic [slh_pkg::CNT_W-1:0]        bin_count_o,
  output logic [slh_pkg::CNT_W-1:0]        hits_counted_o
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int EW = $clog2(MAX_BINS + 1);
  localparam int BW = $clog2(MAX_BINS + 2);
  localparam int CW = slh_pkg::CNT_W;

  slh_pkg::state_e state_q, state_d;

  // Configuration
  logic [slh_pkg::SKIP_W-1:0] skip_q;
  logic                       burst_q;
  logic [TIME_BITS-1:0]       min_cut_q;
  logic [TIME_BITS-1:0]       max_time_q;
  logic [slh_pkg::NBIN_W-1:0] nbins_cfg_q;

  // Request and run state
  slh_pkg::action_e     act_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [BW-1:0]        idx_q;
  logic [AW-1:0]        head_q;
  logic [FW-1:0]        fill_q;
  logic [TIME_BITS-1:0] first_q;
  logic                 first_vld_q;
  logic [CW-1:0]        hit_cnt_q;
  logic [TIME_BITS-1:0] d_q;
  logic [BW-1:0]        e_idx_q;
  logic                 pend_q;
  logic                 rd_ok_q;

  // Result registers
  logic          kept_q;
  logic          filled_q;
  logic [BW-1:0] bin_q;
  logic [CW-1:0] count_q;

  logic accept;
  logic [BW-1:0] nbins;
  logic [TIME_BITS-1:0] first_eff;

  // Shared unit
  logic [TIME_BITS-1:0] u_a, u_b, u_lim, u_diff;
  logic                 u_neg, u_gt;

  // Window addressing
  logic [FW:0]   last_sum, wr_sum, pos_sum;
  logic [AW-1:0] last_idx, wr_idx, pos_idx;
  logic          evict;
  logic [AW-1:0] head_n;
  logic [FW-1:0] fill_m, fill_n;
  logic          fill_ok;
  logic          issue;

  // Memory controls
  logic                 win_we;
  logic [AW-1:0]        win_raddr;
  logic [TIME_BITS-1:0] win_rdata;
  logic                 edge_we;
  logic [TIME_BITS-1:0] edge_rdata;
  logic                 cnt_clr, cnt_we;
  logic [BW-1:0]        cnt_raddr;
  logic [CW-1:0]        cnt_rdata, cnt_wdata;

  assign accept    = start_i && !busy_o;
  assign first_eff = first_vld_q ? first_q : ts_q;

  always_comb begin
    if (nbins_cfg_q == '0) begin
      nbins = BW'(1);
    end else if (32'(nbins_cfg_q) > 32'(MAX_BINS)) begin
      nbins = BW'(MAX_BINS);
    end else begin
      nbins = BW'(nbins_cfg_q);
    end
  end

  always_comb begin
    last_sum = (FW+1)'(head_q) + (FW+1)'(fill_q) - (FW+1)'(1);
    last_idx = (last_sum >= (FW+1)'(WINDOW_DEPTH)) ?
               AW'(last_sum - (FW+1)'(WINDOW_DEPTH)) : AW'(last_sum);
    // A full window drops its oldest entry before the new hit goes in.
    evict  = (fill_q == FW'(WINDOW_DEPTH));
    head_n = evict ? ((32'(head_q) == WINDOW_DEPTH - 1) ? '0 : head_q + AW'(1)) : head_q;
    fill_m = evict ? fill_q - FW'(1) : fill_q;
    fill_n = fill_m + FW'(1);
    wr_sum = (FW+1)'(head_n) + (FW+1)'(fill_m);
    wr_idx = (wr_sum >= (FW+1)'(WINDOW_DEPTH)) ?
             AW'(wr_sum - (FW+1)'(WINDOW_DEPTH)) : AW'(wr_sum);
    pos_sum = (FW+1)'(head_n) + (FW+1)'(fill_n) - (FW+1)'(skip_q) - (FW+1)'(2);
    pos_idx = (pos_sum >= (FW+1)'(WINDOW_DEPTH)) ?
              AW'(pos_sum - (FW+1)'(WINDOW_DEPTH)) : AW'(pos_sum);
    fill_ok = (32'(skip_q) + 32'd3) <= 32'(fill_n);
    issue   = (e_idx_q <= nbins);
  end

  // Operand selection for the shared unit
  always_comb begin
    u_a   = ts_q;
    u_b   = win_rdata;
    u_lim = '0;
    case (state_q)
      slh_pkg::S_LIMIT: begin
        u_b   = first_eff;
        u_lim = max_time_q;
      end
      slh_pkg::S_BURST: begin
        u_lim = min_cut_q;
      end
      slh_pkg::S_SWEEP: begin
        u_a = d_q;
        u_b = edge_rdata;
      end
      default: begin
        u_lim = '0;
      end
    endcase
  end

  slh_sub_cmp #(.W(TIME_BITS)) u_sub_cmp (
    .a_i    (u_a),
    .b_i    (u_b),
    .lim_i  (u_lim),
    .diff_o (u_diff),
    .neg_o  (u_neg),
    .gt_o   (u_gt)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slh_pkg::S_IDLE: begin
        if (accept) begin
          case (slh_pkg::action_e'(action_i))
            slh_pkg::ACT_HIT:  state_d = slh_pkg::S_LIMIT;
            slh_pkg::ACT_READ: state_d = slh_pkg::S_RDCNT;
            default:           state_d = slh_pkg::S_RESP;
          endcase
        end
      end
      slh_pkg::S_LIMIT: begin
        if (u_gt) begin
          state_d = slh_pkg::S_RESP;
        end else if (fill_q == '0 || !burst_q) begin
          state_d = slh_pkg::S_KEEP;
        end else begin
          state_d = slh_pkg::S_BURST;
        end
      end
      slh_pkg::S_BURST: state_d = u_gt ? slh_pkg::S_KEEP : slh_pkg::S_RESP;
      slh_pkg::S_KEEP:  state_d = fill_ok ? slh_pkg::S_DIFF : slh_pkg::S_RESP;
      slh_pkg::S_DIFF:  state_d = u_neg ? slh_pkg::S_RMW : slh_pkg::S_SWEEP;
      slh_pkg::S_SWEEP: begin
        if (!issue && !pend_q) begin
          state_d = slh_pkg::S_RMW;
        end
      end
      slh_pkg::S_RMW:    state_d = slh_pkg::S_WB;
      slh_pkg::S_WB:     state_d = slh_pkg::S_RESP;
      slh_pkg::S_RDCNT:  state_d = slh_pkg::S_CNTCAP;
      slh_pkg::S_CNTCAP: state_d = slh_pkg::S_RESP;
      slh_pkg::S_RESP:   state_d = slh_pkg::S_IDLE;
      default:           state_d = slh_pkg::S_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    busy_o    = (state_q != slh_pkg::S_IDLE);
    done_o    = (state_q == slh_pkg::S_RESP);
    win_we    = (state_q == slh_pkg::S_KEEP);
    win_raddr = (state_q == slh_pkg::S_KEEP) ? pos_idx : last_idx;
    edge_we   = accept && (slh_pkg::action_e'(action_i) == slh_pkg::ACT_EDGE) &&
                (32'(bin_index_i) <= 32'(MAX_BINS));
    cnt_clr   = accept && (slh_pkg::action_e'(action_i) == slh_pkg::ACT_START);
    cnt_we    = (state_q == slh_pkg::S_WB);
    cnt_raddr = (state_q == slh_pkg::S_RDCNT) ? idx_q : bin_q;
    cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CW'(1);
  end

  slh_window #(.DEPTH(WINDOW_DEPTH), .W(TIME_BITS)) u_window (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wr_idx),
    .wdata_i (ts_q),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  slh_hist #(.MAX_BINS(MAX_BINS), .W(TIME_BITS)) u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_we_i    (edge_we),
    .edge_waddr_i (EW'(bin_index_i)),
    .edge_wdata_i (edge_value_i),
    .edge_raddr_i (EW'(e_idx_q)),
    .edge_rdata_o (edge_rdata),
    .cnt_clr_i    (cnt_clr),
    .cnt_we_i     (cnt_we),
    .cnt_waddr_i  (bin_q),
    .cnt_wdata_i  (cnt_wdata),
    .cnt_raddr_i  (cnt_raddr),
    .cnt_rdata_o  (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slh_pkg::S_IDLE;
      skip_q      <= '0;
      burst_q     <= 1'b0;
      min_cut_q   <= TIME_BITS'(slh_pkg::MIN_CUT_RST);
      max_time_q  <= '1;
      nbins_cfg_q <= slh_pkg::NBIN_W'(slh_pkg::NBIN_RST);
      act_q       <= slh_pkg::ACT_HIT;
      ts_q        <= '0;
      idx_q       <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      first_q     <= '0;
      first_vld_q <= 1'b0;
      hit_cnt_q   <= '0;
      d_q         <= '0;
      e_idx_q     <= '0;
      pend_q      <= 1'b0;
      rd_ok_q     <= 1'b0;
      kept_q      <= 1'b0;
      filled_q    <= 1'b0;
      bin_q       <= '0;
      count_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (slh_pkg::reg_e'(cfg_addr_i))
          slh_pkg::REG_SKIP:     skip_q      <= cfg_wdata_i[slh_pkg::SKIP_W-1:0];
          slh_pkg::REG_BURST:    burst_q     <= cfg_wdata_i[0];
          slh_pkg::REG_MIN_CUT:  min_cut_q   <= cfg_wdata_i;
          slh_pkg::REG_MAX_TIME: max_time_q  <= cfg_wdata_i;
          slh_pkg::REG_NBINS:    nbins_cfg_q <= cfg_wdata_i[slh_pkg::NBIN_W-1:0];
          default:               skip_q      <= skip_q;
        endcase
      end
      case (state_q)
        slh_pkg::S_IDLE: begin
          if (accept) begin
            act_q    <= slh_pkg::action_e'(action_i);
            ts_q     <= timestamp_i;
            idx_q    <= bin_index_i;
            kept_q   <= 1'b0;
            filled_q <= 1'b0;
            bin_q    <= '0;
            count_q  <= '0;
            rd_ok_q  <= 32'(bin_index_i) <= 32'(MAX_BINS + 1);
            if (slh_pkg::action_e'(action_i) == slh_pkg::ACT_START) begin
              first_q     <= timestamp_i;
              first_vld_q <= 1'b1;
              hit_cnt_q   <= '0;
              head_q      <= '0;
              fill_q      <= '0;
            end
          end
        end
        slh_pkg::S_LIMIT: begin
          first_q     <= first_eff;
          first_vld_q <= 1'b1;
          if (!u_gt && hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + CW'(1);
          end
        end
        slh_pkg::S_KEEP: begin
          kept_q <= 1'b1;
          head_q <= head_n;
          fill_q <= fill_n;
        end
        slh_pkg::S_DIFF: begin
          d_q     <= u_diff;
          e_idx_q <= '0;
          pend_q  <= 1'b0;
        end
        slh_pkg::S_SWEEP: begin
          // Read of edge e_idx_q goes out while the previous edge is compared.
          if (pend_q && !u_neg) begin
            bin_q <= bin_q + BW'(1);
          end
          pend_q <= issue;
          if (issue) begin
            e_idx_q <= e_idx_q + BW'(1);
          end
        end
        slh_pkg::S_RMW: begin
          filled_q <= 1'b1;
        end
        slh_pkg::S_CNTCAP: begin
          count_q <= rd_ok_q ? cnt_rdata : '0;
        end
        default: begin
          pend_q <= pend_q;
        end
      endcase
    end
  end

  assign hit_kept_o     = kept_q;
  assign bin_filled_o   = filled_q;
  assign filled_bin_o   = bin_q;
  assign bin_count_o    = count_q;
  assign hits_counted_o = hit_cnt_q;

  `SLH_ASSERT_NXT(a_accept_busy, accept, busy_o, "request accepted but block not busy")
  `SLH_ASSERT_IMP(a_fill_range, 1'b1, 32'(fill_q) <= WINDOW_DEPTH, "window fill out of range")
  `SLH_ASSERT_IMP(a_fill_kept, done_o && bin_filled_o, hit_kept_o && act_q == slh_pkg::ACT_HIT,
                  "bin filled without a kept hit")
  `SLH_ASSERT_IMP(a_bin_range, done_o && bin_filled_o, filled_bin_o <= nbins + BW'(1),
                  "filled bin beyond overflow bin")

endmodule
